/* rtl/gpd_pkg.sv */
// ----------------------------------------------------------------------------
// Grid peak detector package
// Shared widths, sizes, register indexes and compare-unit control types.
// ----------------------------------------------------------------------------
`default_nettype none

package gpd_pkg;

    // Field widths of the ports.
    localparam int HEIGHT_W  = 16;
    localparam int SIZE_W    = 6;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Default grid limits.
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    // Reset value of both size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // Operand fetch steps for one cell decision.
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_UP     = 3'd1;
    localparam logic [2:0] STEP_DOWN   = 3'd2;
    localparam logic [2:0] STEP_LEFT   = 3'd3;
    localparam logic [2:0] STEP_RIGHT  = 3'd4;

    typedef logic signed [HEIGHT_W-1:0] height_t;

    // Operand source of the shared comparator.
    typedef enum logic [1:0] {
        OPD_MEM,
        OPD_SAMPLE,
        OPD_ZERO
    } opd_sel_t;

    // Control of the shared comparator for one cycle.
    typedef struct packed {
        logic     load;
        logic     check;
        opd_sel_t sel;
    } cmp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/gpd_line_store.sv */
// ----------------------------------------------------------------------------
// Line store
// Two row banks of heights: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_line_store #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/gpd_compare_unit.sv */
// ----------------------------------------------------------------------------
// Shared compare unit
// Holds the center height of the cell under test and folds one signed
// compare per cycle into a running peak flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_compare_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gpd_pkg::cmp_ctrl_t ctrl,
    input  wire gpd_pkg::height_t   rdata,
    input  wire gpd_pkg::height_t   sample,
    output logic                    peak
);

    import gpd_pkg::*;

    height_t center_reg;
    height_t center_next;
    logic    peak_reg;
    logic    peak_next;
    height_t operand;

    // Operand selection.
    always_comb
    begin
        case (ctrl.sel)
            OPD_MEM:    operand = rdata;
            OPD_SAMPLE: operand = sample;
            default:    operand = '0;
        endcase
    end

    // Load the center or fold in one comparison.
    always_comb
    begin
        center_next = center_reg;
        peak_next   = peak_reg;
        if (ctrl.load)
        begin
            center_next = rdata;
            peak_next   = 1'b1;
        end
        else if (ctrl.check)
        begin
            peak_next = peak_reg & (center_reg >= operand);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            peak_reg   <= 1'b0;
        end
        else
        begin
            center_reg <= center_next;
            peak_reg   <= peak_next;
        end
    end

    assign peak = peak_reg;

endmodule

`default_nettype wire

/* rtl/gpd_sequencer.sv */
// ----------------------------------------------------------------------------
// Peak detector sequencer
// Steps through the operand fetches of each cell, writes the new sample,
// runs the end-of-grid flush and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_sequencer #(
    parameter int COL_W    = 5,
    parameter int RW       = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire gpd_pkg::height_t              height,
    input  wire logic [RW:0]                   rows_eff,
    input  wire logic [COL_W:0]                cols_eff,
    input  wire logic                          cmp_peak,
    output gpd_pkg::cmp_ctrl_t                 cmp_ctrl,
    output gpd_pkg::height_t                   sample,
    output logic                               mem_we,
    output logic [COL_W:0]                     mem_waddr,
    output logic [COL_W:0]                     mem_raddr,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [gpd_pkg::POS_W-1:0]          out_row,
    output logic [gpd_pkg::POS_W-1:0]          out_col,
    output logic                               out_last
);

    import gpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_RESULT,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic             decide_reg, decide_next;
    logic [2:0]       step_reg, step_next;
    logic [COL_W-1:0] x_reg, x_next;
    height_t          sample_reg, sample_next;
    logic [RW-1:0]    row_count_reg, row_count_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic             bank_reg, bank_next;
    logic             end_row_reg, end_row_next;
    logic             end_grid_reg, end_grid_next;
    cmp_ctrl_t        ctrl_reg, ctrl_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [RW-1:0]    pend_row_reg, pend_row_next;
    logic [COL_W-1:0] pend_col_reg, pend_col_next;
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_row_reg, out_row_next;
    logic [POS_W-1:0] out_col_reg, out_col_next;
    logic             out_last_reg, out_last_next;

    logic             cb;
    logic             ob;
    logic [COL_W:0]   x_inc;
    logic             left_ok;
    logic             right_ok;
    logic             up_ok;
    logic             out_free;
    logic             adv;
    logic [RW-1:0]    found_row;
    logic [COL_W:0]   col_inc;
    logic [RW:0]      row_inc;

    // Neighbor availability and bank selection for the cell under test.
    always_comb
    begin
        cb        = decide_reg ? bank_reg : ~bank_reg;
        ob        = ~cb;
        x_inc     = {1'b0, x_reg} + (COL_W+1)'(1);
        left_ok   = (x_reg != '0);
        right_ok  = (x_inc < cols_eff);
        up_ok     = decide_reg ? ({1'b0, row_count_reg} >= (RW+1)'(2))
                               : (row_count_reg != '0);
        out_free  = !out_valid_reg || !out_stall;
        found_row = decide_reg ? (row_count_reg - RW'(1)) : row_count_reg;
        col_inc   = {1'b0, col_count_reg} + (COL_W+1)'(1);
        row_inc   = {1'b0, row_count_reg} + (RW+1)'(1);
    end

    // Next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        decide_next     = decide_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        sample_next     = sample_reg;
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        bank_next       = bank_reg;
        end_row_next    = end_row_reg;
        end_grid_next   = end_grid_reg;
        ctrl_next       = '{load: 1'b0, check: 1'b0, sel: OPD_ZERO};
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        out_valid_next  = out_valid_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_last_next   = out_last_reg;
        mem_raddr       = {cb, x_reg};
        mem_we          = 1'b0;
        adv             = 1'b1;

        // The receiver takes the held beat.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next   = height;
                    x_next        = col_count_reg;
                    decide_next   = 1'b1;
                    step_next     = STEP_CENTER;
                    end_row_next  = (col_inc >= cols_eff);
                    end_grid_next = (col_inc >= cols_eff) && (row_inc >= rows_eff);
                    state_next    = (row_count_reg != '0) ? S_ISSUE : S_WRITE;
                end
            end

            // One operand fetch per cycle into the shared comparator.
            S_ISSUE:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    STEP_CENTER:
                    begin
                        ctrl_next = '{load: 1'b1, check: 1'b0, sel: OPD_MEM};
                        mem_raddr = {cb, x_reg};
                    end
                    STEP_UP:
                    begin
                        ctrl_next = '{load: 1'b0, check: 1'b1,
                                      sel: (up_ok ? OPD_MEM : OPD_ZERO)};
                        mem_raddr = {ob, x_reg};
                    end
                    STEP_DOWN:
                    begin
                        ctrl_next = '{load: 1'b0, check: 1'b1,
                                      sel: (decide_reg ? OPD_SAMPLE : OPD_ZERO)};
                    end
                    STEP_LEFT:
                    begin
                        ctrl_next = '{load: 1'b0, check: 1'b1,
                                      sel: (left_ok ? OPD_MEM : OPD_ZERO)};
                        mem_raddr = {cb, x_reg - COL_W'(1)};
                    end
                    STEP_RIGHT:
                    begin
                        ctrl_next  = '{load: 1'b0, check: 1'b1,
                                       sel: (right_ok ? OPD_MEM : OPD_ZERO)};
                        mem_raddr  = {cb, x_inc[COL_W-1:0]};
                        state_next = S_DRAIN;
                    end
                    default:
                    begin
                        state_next = S_DRAIN;
                    end
                endcase
            end

            S_DRAIN:
            begin
                state_next = S_RESULT;
            end

            // A new peak pushes the pending one out, which is then not last.
            S_RESULT:
            begin
                if (cmp_peak)
                begin
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = POS_W'(pend_row_reg);
                            out_col_next   = POS_W'(pend_col_reg);
                            out_last_next  = 1'b0;
                        end
                        else
                        begin
                            adv = 1'b0;
                        end
                    end
                    if (adv)
                    begin
                        pend_valid_next = 1'b1;
                        pend_row_next   = found_row;
                        pend_col_next   = x_reg;
                    end
                end
                if (adv)
                begin
                    if (decide_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (right_ok)
                    begin
                        x_next     = x_inc[COL_W-1:0];
                        step_next  = STEP_CENTER;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            // Store the sample; the last sample of the grid starts the flush.
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (end_grid_reg)
                begin
                    decide_next = 1'b0;
                    x_next      = '0;
                    step_next   = STEP_CENTER;
                    state_next  = S_ISSUE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // Release the last pending peak and advance the raster position.
            S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_row_next    = POS_W'(pend_row_reg);
                        out_col_next    = POS_W'(pend_col_reg);
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    if (end_grid_reg)
                    begin
                        row_count_next = '0;
                        col_count_next = '0;
                        bank_next      = 1'b0;
                    end
                    else if (end_row_reg)
                    begin
                        col_count_next = '0;
                        row_count_next = row_inc[RW-1:0];
                        bank_next      = ~bank_reg;
                    end
                    else
                    begin
                        col_count_next = col_inc[COL_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            decide_reg     <= 1'b1;
            step_reg       <= STEP_CENTER;
            x_reg          <= '0;
            sample_reg     <= '0;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            bank_reg       <= 1'b0;
            end_row_reg    <= 1'b0;
            end_grid_reg   <= 1'b0;
            ctrl_reg       <= '{load: 1'b0, check: 1'b0, sel: OPD_ZERO};
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_col_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            decide_reg     <= decide_next;
            step_reg       <= step_next;
            x_reg          <= x_next;
            sample_reg     <= sample_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            bank_reg       <= bank_next;
            end_row_reg    <= end_row_next;
            end_grid_reg   <= end_grid_next;
            ctrl_reg       <= ctrl_next;
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
            pend_col_reg   <= pend_col_next;
            out_valid_reg  <= out_valid_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cmp_ctrl  = ctrl_reg;
    assign sample    = sample_reg;
    assign mem_waddr = {~bank_reg, col_count_reg};
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/grid_peak_detector.sv */
// ----------------------------------------------------------------------------
// Grid peak detector
// Four-neighbor local maximum detection on a raster-ordered height grid.
// ----------------------------------------------------------------------------
// Usage:
// Heights enter on the input channel (in_valid, in_stall, height), one beat
// per cell in raster order. A cell is reported on the output channel
// (out_valid, out_stall, peak_row, peak_col, run_last) when it is not lower
// than any of its four neighbors; neighbors outside the grid read as zero.
// A cell is decided when the sample below it arrives, and the last sample of
// the grid also flushes the whole last row. run_last marks the final beat of
// the results caused by one input beat.
// All operands of a cell go through one read port and one signed
// comparator, five operands per cell. A sample in the first row is only
// stored; any other sample first decides the cell above it, and the last
// sample of the grid then decides every cell of the last row for the flush.
// in_stall is high while an item is being worked on. A stalled receiver
// holds the result register; the block waits only when it must load another
// beat. Reset clears the position to the top-left cell and both sizes to 20.
// Size registers are written through cfg_write, cfg_index and cfg_data, by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_peak_detector #(
    parameter int MAX_COLS = gpd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gpd_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [gpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gpd_pkg::SIZE_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [gpd_pkg::HEIGHT_W-1:0] height,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [gpd_pkg::POS_W-1:0]            peak_row,
    output logic [gpd_pkg::POS_W-1:0]            peak_col,
    output logic                                 run_last
);

    import gpd_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [SIZE_W-1:0] grid_rows_reg;
    logic [SIZE_W-1:0] grid_rows_next;
    logic [SIZE_W-1:0] grid_cols_reg;
    logic [SIZE_W-1:0] grid_cols_next;
    logic [RW:0]       rows_eff;
    logic [COL_W:0]    cols_eff;

    cmp_ctrl_t         cmp_ctrl;
    height_t           sample;
    height_t           rdata;
    logic              cmp_peak;
    logic              mem_we;
    logic [COL_W:0]    mem_waddr;
    logic [COL_W:0]    mem_raddr;

    // Configuration registers.
    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_next = cfg_data;
                REG_GRID_COLS: grid_cols_next = cfg_data;
                default:
                begin
                    grid_rows_next = grid_rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= SIZE_RESET;
            grid_cols_reg <= SIZE_RESET;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    // Zero acts as one; oversize values saturate at the limit.
    always_comb
    begin
        if (grid_rows_reg == '0)
        begin
            rows_eff = (RW+1)'(1);
        end
        else if (int'(grid_rows_reg) > MAX_ROWS)
        begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end
        else
        begin
            rows_eff = (RW+1)'(grid_rows_reg);
        end

        if (grid_cols_reg == '0)
        begin
            cols_eff = (COL_W+1)'(1);
        end
        else if (int'(grid_cols_reg) > MAX_COLS)
        begin
            cols_eff = (COL_W+1)'(MAX_COLS);
        end
        else
        begin
            cols_eff = (COL_W+1)'(grid_cols_reg);
        end
    end

    // Two row banks.
    gpd_line_store #(
        .ADDR_W (COL_W + 1),
        .DATA_W (HEIGHT_W)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (sample),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    // Shared signed comparator.
    gpd_compare_unit u_compare_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cmp_ctrl),
        .rdata  (rdata),
        .sample (sample),
        .peak   (cmp_peak)
    );

    // Control sequencer and result register.
    gpd_sequencer #(
        .COL_W    (COL_W),
        .RW       (RW)
    ) u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height    (height),
        .rows_eff  (rows_eff),
        .cols_eff  (cols_eff),
        .cmp_peak  (cmp_peak),
        .cmp_ctrl  (cmp_ctrl),
        .sample    (sample),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_raddr (mem_raddr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (peak_row),
        .out_col   (peak_col),
        .out_last  (run_last)
    );

    // An accepted beat always leaves the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block ready right after accepting a beat");

    // The line store is only written while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> in_stall)
        else $error("line store written while idle");

    // A new result beat is only loaded while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result loaded while idle");

endmodule

`default_nettype wire

/* sim/grid_peak_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid peak checker
// Watches the configuration port and both channels of the grid peak
// detector. It keeps its own copy of the line store, the raster position and
// the grid size, works out the peaks that each accepted height beat decides,
// and compares every accepted result beat with the oldest expected peak.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_peak_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [gpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gpd_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic signed [gpd_pkg::HEIGHT_W-1:0] height,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic [gpd_pkg::POS_W-1:0]           peak_row,
    input  wire logic [gpd_pkg::POS_W-1:0]           peak_col,
    input  wire logic                                run_last,
    output int                                       pending,
    output int                                       fail_count
);

    import gpd_pkg::*;

    localparam int MAX_COLS = MAX_COLS_DEF;
    localparam int MAX_ROWS = MAX_ROWS_DEF;
    localparam height_t ZERO_H = '0;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } peak_t;

    // Shadow state of the detector.
    height_t           line_mem [2*MAX_COLS];
    bit                bank_sel;
    int                row_pos;
    int                col_pos;
    logic [SIZE_W-1:0] grid_rows;
    logic [SIZE_W-1:0] grid_cols;
    peak_t             expected_q [$];
    int                errors = 0;

    // A size of zero acts as one, and sizes above the store act as the maximum.
    function automatic int eff_size(input logic [SIZE_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    // A cell is a peak when no neighbor is higher.
    function automatic bit is_peak(input height_t center, input height_t up,
                                   input height_t down, input height_t left,
                                   input height_t right);
        return center >= up && center >= down && center >= left && center >= right;
    endfunction

    function automatic peak_t make_peak(input int r, input int c);
        peak_t p;
        p.row = r[POS_W-1:0];
        p.col = c[POS_W-1:0];
        p.last = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        end
    endtask

    // Work out the peaks that one height beat decides and queue them in order.
    task automatic predict_peaks(input height_t sample);
        int      rows_eff;
        int      cols_eff;
        int      r;
        int      c;
        int      prev_base;
        int      cur_base;
        height_t up;
        height_t left;
        height_t right;
        peak_t   run_q [$];
        begin
            rows_eff = eff_size(grid_rows, MAX_ROWS);
            cols_eff = eff_size(grid_cols, MAX_COLS);
            r = row_pos;
            c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
            prev_base = bank_sel ? MAX_COLS : 0;
            cur_base = bank_sel ? 0 : MAX_COLS;

            // The new sample is the lower neighbor of the cell above it.
            if (r > 0)
            begin
                up = (r >= 2) ? line_mem[cur_base + c] : ZERO_H;
                left = (c > 0) ? line_mem[prev_base + c - 1] : ZERO_H;
                right = (c + 1 < cols_eff) ? line_mem[prev_base + c + 1] : ZERO_H;
                if (is_peak(line_mem[prev_base + c], up, sample, left, right))
                    run_q.push_back(make_peak(r - 1, c));
            end
            line_mem[cur_base + c] = sample;

            if (c + 1 >= cols_eff && r + 1 >= rows_eff)
            begin
                // Last sample of the grid: the bottom row sees zero below it.
                for (int j = 0; j < cols_eff; j++)
                begin
                    up = (r >= 1) ? line_mem[prev_base + j] : ZERO_H;
                    left = (j > 0) ? line_mem[cur_base + j - 1] : ZERO_H;
                    right = (j + 1 < cols_eff) ? line_mem[cur_base + j + 1] : ZERO_H;
                    if (is_peak(line_mem[cur_base + j], up, ZERO_H, left, right))
                        run_q.push_back(make_peak(r, j));
                end
                row_pos = 0;
                col_pos = 0;
                bank_sel = 1'b0;
            end
            else if (c + 1 >= cols_eff)
            begin
                col_pos = 0;
                row_pos = r + 1;
                bank_sel = !bank_sel;
            end
            else
            begin
                col_pos = c + 1;
            end

            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i])
                expected_q.push_back(run_q[i]);
        end
    endtask

    // Compare one accepted result beat with the oldest expected peak.
    task automatic check_peak();
        peak_t want;
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("peak at row %0d col %0d with none expected",
                                          peak_row, peak_col));
            end
            else
            begin
                want = expected_q.pop_front();
                if (peak_row !== want.row)
                    report_mismatch($sformatf("peak_row %0d, expected %0d (col %0d)",
                                              peak_row, want.row, want.col));
                if (peak_col !== want.col)
                    report_mismatch($sformatf("peak_col %0d, expected %0d (row %0d)",
                                              peak_col, want.col, want.row));
                if (run_last !== want.last)
                    report_mismatch($sformatf("run_last %0b, expected %0b at row %0d col %0d",
                                              run_last, want.last, want.row, want.col));
            end
        end
    endtask

    // Follow the configuration port and both channels edge by edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (line_mem[i])
                line_mem[i] = ZERO_H;
            bank_sel = 1'b0;
            row_pos = 0;
            col_pos = 0;
            grid_rows = SIZE_RESET;
            grid_cols = SIZE_RESET;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_GRID_ROWS)
                    grid_rows = cfg_data;
                else
                    grid_cols = cfg_data;
            end
            if (out_valid && !out_stall)
                check_peak();
            if (in_valid && !in_stall)
                predict_peaks(height);
            pending <= expected_q.size();
        end
        fail_count <= errors;
    end

endmodule

`default_nettype wire

/* sim/grid_peak_detector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid peak detector testbench
// Streams height grids into the detector: a few small directed grids with
// extreme heights, ties and degenerate sizes, then random grids of random
// size, some cut short by a size change. Both channels idle in random
// bursts. A checker beside the block predicts and compares every peak.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_peak_detector_test;

    import gpd_pkg::*;

    localparam int MAX_COLS = MAX_COLS_DEF;
    localparam int MAX_ROWS = MAX_ROWS_DEF;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_WELL_FORMED_AREA = 80;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_FLAT,
        MIX_EDGE
    } height_mix_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_ROWS;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    height_t              height = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [POS_W-1:0]     peak_row;
    logic [POS_W-1:0]     peak_col;
    logic                 run_last;
    int                   pending;
    int                   fail_count;

    // Stimulus state: idling mode and the raster position of the next beat.
    bit gappy = 1'b1;
    bit calm = 1'b0;
    int stall_left = 0;
    int rows_eff = 20;
    int cols_eff = 20;
    int cur_row = 0;
    int cur_col = 0;
    int random_sent = 0;

    grid_peak_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height    (height),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .peak_row  (peak_row),
        .peak_col  (peak_col),
        .run_last  (run_last)
    );

    grid_peak_checker u_peak_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .height     (height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .peak_row   (peak_row),
        .peak_col   (peak_col),
        .run_last   (run_last),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls in random bursts while the stimulus is gappy and not calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (gappy && !calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic int clamp_size(input logic [SIZE_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    // Mostly a narrow size, now and then zero, a large size or an oversize value.
    function automatic logic [SIZE_W-1:0] pick_size(input int common_max);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SIZE_W'($urandom_range(32, 63));
            2: return SIZE_W'($urandom_range(1, 31));
            default: return SIZE_W'($urandom_range(1, common_max));
        endcase
    endfunction

    function automatic height_t pick_height(input height_mix_t mix, input height_t level);
        case (mix)
            MIX_WIDE: return height_t'($urandom);
            // Narrow range gives plenty of ties between neighbors.
            MIX_NARROW: return height_t'($urandom_range(0, 6)) - height_t'(3);
            MIX_FLAT: return level;
            default:
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return '0;
                    3: return '1;
                    default: return 16'sd1;
                endcase
        endcase
    endfunction

    // Both size registers go in on back-to-back writes, rows first, then columns.
    task automatic write_size(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_GRID_ROWS;
            cfg_data <= rows;
            @(posedge clk);
            cfg_index <= REG_GRID_COLS;
            cfg_data <= cols;
            @(posedge clk);
            cfg_write <= 1'b0;
            rows_eff = clamp_size(rows, MAX_ROWS);
            cols_eff = clamp_size(cols, MAX_COLS);
        end
    endtask

    // Send one height beat, with an occasional gap in front of it.
    task automatic send_height(input height_t value);
        begin
            if (gappy && !calm && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            in_valid <= 1'b1;
            height <= value;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);

            // Step the raster position the same way the block does.
            if (cur_col + 1 >= cols_eff)
            begin
                cur_col = 0;
                cur_row = (cur_row + 1 >= rows_eff) ? 0 : cur_row + 1;
            end
            else
            begin
                cur_col = cur_col + 1;
            end
        end
    endtask

    // Hold off until every expected peak is out and the block has gone quiet.
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] rows_val;
        logic [SIZE_W-1:0] cols_val;
        height_mix_t       mix;
        height_t           level;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero sizes act as a single-cell grid; each beat is its own grid.
        wait_idle();
        write_size('0, '0);
        send_height(16'sh7FFF);
        send_height(16'sh8000);
        send_height(16'sh0000);

        // Single row: the flush sees zero above and below.
        wait_idle();
        write_size(6'd1, 6'd4);
        send_height(16'sd5);
        send_height(16'sd5);
        send_height(-16'sd1);
        send_height(16'sd7);

        // Two rows with extreme heights next to each other.
        wait_idle();
        write_size(6'd2, 6'd3);
        send_height(16'sh7FFF);
        send_height(16'sh8000);
        send_height(16'sd100);
        send_height(16'sh8000);
        send_height(16'sh7FFF);
        send_height(16'sh0000);

        // Flat grid: every cell ties with its neighbors.
        wait_idle();
        write_size(6'd3, 6'd3);
        repeat (9) send_height(16'sd7);

        // A flat full-width grid writes every entry of both line banks and
        // makes the last beat return the longest possible run of peaks.
        wait_idle();
        write_size(6'd2, 6'd63);
        level = height_t'($urandom_range(1, 32767));
        repeat (2 * MAX_COLS) send_height(level);
        random_sent += 2 * MAX_COLS;

        // Tallest grid, one column wide.
        wait_idle();
        write_size(6'd63, 6'd1);
        repeat (MAX_ROWS) send_height(pick_height(MIX_NARROW, '0));
        random_sent += MAX_ROWS;

        // Random grids; most run to the end, some stop mid-grid so that the
        // next size change lands in the middle of a grid.
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            gappy = ($urandom_range(0, 3) != 0);
            rows_val = pick_size(5);
            cols_val = pick_size(8);
            write_size(rows_val, cols_val);
            mix = height_mix_t'($urandom_range(0, 3));
            level = height_t'($urandom);
            if ($urandom_range(0, 4) != 0 && rows_eff * cols_eff <= MAX_WELL_FORMED_AREA)
            begin
                do
                begin
                    send_height(pick_height(mix, level));
                    random_sent++;
                end
                while (cur_row != 0 || cur_col != 0);
            end
            else
            begin
                repeat ($urandom_range(1, 2 * cols_eff))
                begin
                    send_height(pick_height(mix, level));
                    random_sent++;
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* grid_peak_detector.f */
rtl/gpd_pkg.sv
rtl/gpd_line_store.sv
rtl/gpd_compare_unit.sv
rtl/gpd_sequencer.sv
rtl/grid_peak_detector.sv
sim/grid_peak_checker.sv
sim/grid_peak_detector_test.sv
